@@ rtl/bffa_pkg.sv @@
// Package for the bitmap first-fit allocator.
// Holds the heap geometry, granule codes, status codes and the reset map image.
// No dependencies.
`timescale 1ns / 1ps
package bffa_pkg;

  localparam int HEAP_ORDER     = 14;
  localparam int RESERVED_BYTES = 256;
  localparam int GRANULES       = 1 << (HEAP_ORDER - 4);
  localparam int HEAP_BYTES     = 1 << HEAP_ORDER;
  localparam int MAP_GRANULES   = 1 << (HEAP_ORDER - 10);
  localparam int RES_GRANULES   = (RESERVED_BYTES + 15) / 16;
  localparam int GPW            = 16;                 // granules per memory word
  localparam int WORDS          = GRANULES / GPW;
  localparam int WORD_W         = 2 * GPW;
  localparam int WADDR_W        = $clog2(WORDS);
  localparam int GIDX_W         = $clog2(GRANULES);
  localparam int GOFF_W         = $clog2(GPW);
  localparam int NEED_W         = GIDX_W + 1;
  localparam int SIZE_W         = 23;
  localparam int FRAG_W         = 32;

  localparam logic [1:0] CODE_CONT  = 2'b00;
  localparam logic [1:0] CODE_START = 2'b01;
  localparam logic [1:0] CODE_FREE  = 2'b11;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OVERSIZE = 2'd1,
    ST_NO_FIT   = 2'd2,
    ST_RANGE    = 2'd3
  } status_t;

  // Map word as it stands after reset: the map area and the reserved area
  // are each one allocated block, everything else is free.
  function automatic logic [WORD_W-1:0] init_word(input logic [WADDR_W-1:0] w);
    logic [WORD_W-1:0] v;
    int g;
    v = '0;
    for (int j = 0; j < GPW; j++) begin
      g = int'(w) * GPW + j;
      if (g == 0 || g == MAP_GRANULES)
        v[2*j +: 2] = CODE_START;
      else if (g < MAP_GRANULES + RES_GRANULES)
        v[2*j +: 2] = CODE_CONT;
      else
        v[2*j +: 2] = CODE_FREE;
    end
    return v;
  endfunction

endpackage

@@ rtl/bffa_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module bffa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/bitmap_first_fit_allocator.sv @@
// Top level of the bitmap first-fit allocator.
// Depends on bffa_pkg and bffa_ram (granule map, 16 granules per word).
//
// After reset the block writes the initial granule map and holds busy high.
// An allocate scans the map words in order, then reads and writes back each
// map word that it marks; an oversized or zero-size request answers straight
// from idle. A free reads and writes back each map word it touches. Each
// word gets exactly one out_strobe cycle; the receiver cannot stall, so take
// it then.
`timescale 1ns / 1ps
module bitmap_first_fit_allocator
  import bffa_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic              in_operation,
  input  logic [SIZE_W-1:0] in_size_bytes,
  input  logic [GIDX_W-1:0] in_block_index,
  output logic              out_strobe,
  output logic [1:0]        out_status,
  output logic [GIDX_W-1:0] out_granted_index,
  output logic [FRAG_W-1:0] out_frag_total
);

  typedef enum logic [7:0] {
    S_INIT  = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_SRD   = 8'b0000_0100,
    S_SCAN  = 8'b0000_1000,
    S_MRD   = 8'b0001_0000,
    S_MWR   = 8'b0010_0000,
    S_FRD   = 8'b0100_0000,
    S_FWR   = 8'b1000_0000
  } state_t;

  state_t              state_r, state_nxt;
  logic [WADDR_W-1:0]  addr_r, addr_nxt;
  logic [NEED_W-1:0]   need_r, need_nxt;
  logic [NEED_W-1:0]   run_r, run_nxt;
  logic [GIDX_W-1:0]   grant_r, grant_nxt;
  logic [GIDX_W-1:0]   last_r, last_nxt;
  logic [GOFF_W-1:0]   foff_r, foff_nxt;
  logic                ffirst_r, ffirst_nxt;
  logic [FRAG_W-1:0]   waste_r, waste_nxt;
  logic                strobe_r, strobe_nxt;
  status_t             status_r, status_nxt;
  logic [GIDX_W-1:0]   gidx_r, gidx_nxt;

  logic                we;
  logic [WADDR_W-1:0]  raddr;
  logic [WORD_W-1:0]   wdata, rdata;

  bffa_ram #(.WIDTH(WORD_W), .DEPTH(WORDS)) u_map (
    .clk   (clk),
    .we    (we),
    .waddr (addr_r),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Request decode.
  logic [SIZE_W:0]   size_up;
  logic [NEED_W-1:0] req_need;
  logic              oversize;
  logic [FRAG_W:0]   waste_sum;
  always_comb begin
    size_up   = {1'b0, in_size_bytes} + (SIZE_W+1)'(15);
    req_need  = size_up[NEED_W+3:4];
    oversize  = in_size_bytes > SIZE_W'(HEAP_BYTES);
    waste_sum = {1'b0, waste_r} + (FRAG_W+1)'(4'(-in_size_bytes[3:0]));
  end

  // Scan of one word: the first granule at which a long enough free run ends.
  logic [GOFF_W:0]   trail [GPW];
  logic              hit;
  logic [GOFF_W-1:0] hit_pos;
  logic [NEED_W-1:0] cand;
  logic [NEED_W-1:0] run_out;
  always_comb begin
    hit     = 1'b0;
    hit_pos = '0;
    cand    = '0;
    for (int j = 0; j < GPW; j++) begin
      trail[j] = '0;
      for (int k = 0; k <= j; k++) begin
        if (rdata[2*k +: 2] == CODE_FREE) trail[j] = trail[j] + 1'b1;
        else trail[j] = '0;
      end
    end
    for (int j = GPW - 1; j >= 0; j--) begin
      if (trail[j] == (GOFF_W+1)'(j + 1))
        cand = run_r + NEED_W'(j + 1);
      else
        cand = NEED_W'(trail[j]);
      if (rdata[2*j +: 2] == CODE_FREE && cand >= need_r) begin
        hit     = 1'b1;
        hit_pos = GOFF_W'(j);
      end
    end
    if (trail[GPW-1] == (GOFF_W+1)'(GPW))
      run_out = run_r + NEED_W'(GPW);
    else
      run_out = NEED_W'(trail[GPW-1]);
  end

  logic [NEED_W-1:0] hit_start;
  assign hit_start = {1'b0, addr_r, hit_pos} + NEED_W'(1) - need_r;

  // Marking of one word for the block being allocated.
  logic [WORD_W-1:0] mark_word;
  logic [GIDX_W-1:0] g_here;
  always_comb begin
    mark_word = rdata;
    g_here    = '0;
    for (int j = 0; j < GPW; j++) begin
      g_here = {addr_r, GOFF_W'(j)};
      if (g_here == grant_r) mark_word[2*j +: 2] = CODE_START;
      else if (g_here > grant_r && g_here <= last_r) mark_word[2*j +: 2] = CODE_CONT;
    end
  end

  // Freeing of one word: the named granule, then the continuation chain.
  logic [WORD_W-1:0] free_word;
  logic              chain;
  logic [GOFF_W:0]   lo;
  always_comb begin
    free_word = rdata;
    lo        = ffirst_r ? ({1'b0, foff_r} + 1'b1) : '0;
    chain     = 1'b1;
    for (int j = 0; j < GPW; j++) begin
      if (ffirst_r && GOFF_W'(j) == foff_r) begin
        free_word[2*j +: 2] = CODE_FREE;
      end else if ((GOFF_W+1)'(j) >= lo) begin
        if (rdata[2*j +: 2] != CODE_CONT) chain = 1'b0;
        if (chain) free_word[2*j +: 2] = CODE_FREE;
      end
    end
  end

  always_comb begin
    state_nxt  = state_r;
    addr_nxt   = addr_r;
    need_nxt   = need_r;
    run_nxt    = run_r;
    grant_nxt  = grant_r;
    last_nxt   = last_r;
    foff_nxt   = foff_r;
    ffirst_nxt = ffirst_r;
    waste_nxt  = waste_r;
    strobe_nxt = 1'b0;
    status_nxt = status_r;
    gidx_nxt   = gidx_r;
    we         = 1'b0;
    wdata      = rdata;
    raddr      = addr_r;

    case (state_r)
      S_INIT: begin
        we    = 1'b1;
        wdata = init_word(addr_r);
        addr_nxt = addr_r + 1'b1;
        if (addr_r == WADDR_W'(WORDS - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          if (in_operation == OP_ALLOC) begin
            if (oversize) begin
              strobe_nxt = 1'b1;
              status_nxt = ST_OVERSIZE;
              gidx_nxt   = '0;
            end else begin
              waste_nxt = waste_sum[FRAG_W] ? '1 : waste_sum[FRAG_W-1:0];
              if (req_need == '0) begin
                strobe_nxt = 1'b1;
                status_nxt = ST_NO_FIT;
                gidx_nxt   = '0;
              end else begin
                need_nxt  = req_need;
                run_nxt   = '0;
                addr_nxt  = '0;
                state_nxt = S_SRD;
              end
            end
          end else begin
            addr_nxt   = in_block_index[GIDX_W-1:GOFF_W];
            foff_nxt   = in_block_index[GOFF_W-1:0];
            ffirst_nxt = 1'b1;
            state_nxt  = S_FRD;
          end
        end
      end
      S_SRD: begin
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        // Prefetch the next word while this one is examined.
        raddr = addr_r + 1'b1;
        if (hit) begin
          grant_nxt = hit_start[GIDX_W-1:0];
          last_nxt  = {addr_r, hit_pos};
          addr_nxt  = hit_start[GIDX_W-1:GOFF_W];
          state_nxt = S_MRD;
        end else if (addr_r == WADDR_W'(WORDS - 1)) begin
          strobe_nxt = 1'b1;
          status_nxt = ST_NO_FIT;
          gidx_nxt   = '0;
          state_nxt  = S_IDLE;
        end else begin
          run_nxt  = run_out;
          addr_nxt = addr_r + 1'b1;
        end
      end
      S_MRD: begin
        state_nxt = S_MWR;
      end
      S_MWR: begin
        we    = 1'b1;
        wdata = mark_word;
        if (addr_r == last_r[GIDX_W-1:GOFF_W]) begin
          strobe_nxt = 1'b1;
          status_nxt = ST_OK;
          gidx_nxt   = grant_r;
          state_nxt  = S_IDLE;
        end else begin
          addr_nxt  = addr_r + 1'b1;
          state_nxt = S_MRD;
        end
      end
      S_FRD: begin
        state_nxt = S_FWR;
      end
      S_FWR: begin
        we         = 1'b1;
        wdata      = free_word;
        ffirst_nxt = 1'b0;
        if (chain && addr_r != WADDR_W'(WORDS - 1)) begin
          addr_nxt  = addr_r + 1'b1;
          state_nxt = S_FRD;
        end else begin
          strobe_nxt = 1'b1;
          status_nxt = ST_OK;
          gidx_nxt   = '0;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_INIT;
        addr_nxt  = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_INIT;
      addr_r   <= '0;
      waste_r  <= '0;
      strobe_r <= 1'b0;
      ffirst_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      addr_r   <= addr_nxt;
      waste_r  <= waste_nxt;
      strobe_r <= strobe_nxt;
      ffirst_r <= ffirst_nxt;
    end
  end

  always_ff @(posedge clk) begin
    need_r   <= need_nxt;
    run_r    <= run_nxt;
    grant_r  <= grant_nxt;
    last_r   <= last_nxt;
    foff_r   <= foff_nxt;
    status_r <= status_nxt;
    gidx_r   <= gidx_nxt;
  end

  assign busy              = (state_r != S_IDLE);
  assign out_strobe        = strobe_r;
  assign out_status        = status_r;
  assign out_granted_index = gidx_r;
  assign out_frag_total    = waste_r;

endmodule

@@ tb/sv/testbench.sv @@
// Self-checking testbench for the bitmap first-fit allocator.
// Predicts every result from its own copy of the granule map; uses bffa_pkg.
// Stimulus is directed edge cases followed by random allocate/free traffic.
`timescale 1ns / 1ps
module testbench;
  import bffa_pkg::*;

  typedef struct {
    status_t           status;
    logic [GIDX_W-1:0] granted;
    logic [FRAG_W-1:0] frag;
  } alloc_result_t;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic              in_operation;
  logic [SIZE_W-1:0] in_size_bytes;
  logic [GIDX_W-1:0] in_block_index;
  logic              out_strobe;
  logic [1:0]        out_status;
  logic [GIDX_W-1:0] out_granted_index;
  logic [FRAG_W-1:0] out_frag_total;

  logic [1:0]        heap_map [GRANULES];
  logic [FRAG_W-1:0] waste_total;
  alloc_result_t     pending_results [$];
  logic [GIDX_W-1:0] live_blocks [$];
  int                mismatches;

  bitmap_first_fit_allocator i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_operation      (in_operation),
    .in_size_bytes     (in_size_bytes),
    .in_block_index    (in_block_index),
    .out_strobe        (out_strobe),
    .out_status        (out_status),
    .out_granted_index (out_granted_index),
    .out_frag_total    (out_frag_total)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  initial begin
    #20ms;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic void reset_heap_map();
    for (int g = 0; g < GRANULES; g++) begin
      if (g == 0 || g == MAP_GRANULES)
        heap_map[g] = CODE_START;
      else if (g < MAP_GRANULES + RES_GRANULES)
        heap_map[g] = CODE_CONT;
      else
        heap_map[g] = CODE_FREE;
    end
    waste_total = '0;
  endfunction

  // Applies one request to the model map and returns the expected word.
  function automatic alloc_result_t predict_allocation(logic op, logic [SIZE_W-1:0] size,
                                                       logic [GIDX_W-1:0] idx);
    alloc_result_t r;
    int rounded;
    int need;
    int run;
    int found;
    r.status  = ST_OK;
    r.granted = '0;
    found     = -1;
    if (op == OP_ALLOC) begin
      if (int'(size) > HEAP_BYTES) begin
        r.status = ST_OVERSIZE;
      end else begin
        rounded = (int'(size) + 15) & ~15;
        need    = rounded / 16;
        run     = 0;
        if (waste_total > 32'hFFFF_FFFF - (rounded - int'(size)))
          waste_total = 32'hFFFF_FFFF;
        else
          waste_total = waste_total + (rounded - int'(size));
        if (need != 0) begin
          for (int g = 0; g < GRANULES && found < 0; g++) begin
            if (heap_map[g] == CODE_FREE) begin
              run++;
              if (run == need)
                found = g + 1 - need;
            end else begin
              run = 0;
            end
          end
        end
        if (found >= 0) begin
          r.granted = GIDX_W'(found);
          for (int k = 0; k < need; k++)
            heap_map[found + k] = (k == 0) ? CODE_START : CODE_CONT;
          live_blocks.push_back(GIDX_W'(found));
        end else begin
          r.status = ST_NO_FIT;
        end
      end
    end else begin
      if (int'(idx) >= GRANULES) begin
        r.status = ST_RANGE;
      end else begin
        heap_map[idx] = CODE_FREE;
        for (int g = int'(idx) + 1; g < GRANULES; g++) begin
          if (heap_map[g] != CODE_CONT)
            break;
          heap_map[g] = CODE_FREE;
        end
      end
    end
    r.frag = waste_total;
    return r;
  endfunction

  // Called at a rising edge; returns at the edge where the request is taken, or after the gap.
  task automatic send_request(logic op, logic [SIZE_W-1:0] size, logic [GIDX_W-1:0] idx,
                              int gap);
    start          <= 1'b1;
    in_operation   <= op;
    in_size_bytes  <= size;
    in_block_index <= idx;
    forever begin
      @(negedge clk);
      if (!busy)
        break;
    end
    @(posedge clk);
    pending_results.push_back(predict_allocation(op, size, idx));
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic int random_gap();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 50)
      return 0;
    else if (pick < 92)
      return $urandom_range(1, 3);
    else
      return $urandom_range(20, 80);
  endfunction

  task automatic wait_for_results();
    start <= 1'b0;
    while (pending_results.size() != 0)
      @(posedge clk);
  endtask

  task automatic test_directed();
    send_request(OP_ALLOC, 0, 0, random_gap());
    send_request(OP_ALLOC, 1, 0, random_gap());
    send_request(OP_ALLOC, 15, 0, random_gap());
    send_request(OP_ALLOC, 16, 0, random_gap());
    send_request(OP_ALLOC, 17, 0, random_gap());
    send_request(OP_ALLOC, SIZE_W'(HEAP_BYTES), 0, random_gap());
    send_request(OP_ALLOC, SIZE_W'(HEAP_BYTES + 1), 0, random_gap());
    send_request(OP_ALLOC, {SIZE_W{1'b1}}, 0, random_gap());
    // Free inside the reserved block splits it.
    send_request(OP_FREE, 0, 24, random_gap());
    send_request(OP_FREE, 0, 20, 0);
    send_request(OP_FREE, 0, 21, 0);
    send_request(OP_FREE, 0, 22, 0);
    send_request(OP_FREE, 0, 23, random_gap());
    // The whole free tail: the run ends at the last granule.
    send_request(OP_ALLOC, SIZE_W'((GRANULES - 37) * 16), 0, random_gap());
    send_request(OP_ALLOC, 16, 0, random_gap());
    send_request(OP_FREE, 0, GIDX_W'(GRANULES - 1), random_gap());
    send_request(OP_ALLOC, 16, 0, random_gap());
    send_request(OP_FREE, 0, 20, random_gap());
    send_request(OP_FREE, 0, 0, random_gap());
    send_request(OP_FREE, 0, GIDX_W'(MAP_GRANULES), random_gap());
    send_request(OP_FREE, 0, 512, random_gap());
    send_request(OP_ALLOC, SIZE_W'(HEAP_BYTES), 0, random_gap());
    send_request(OP_FREE, 0, 0, random_gap());
    send_request(OP_ALLOC, 16, 0, random_gap());
    live_blocks.delete();
  endtask

  task automatic test_random(int count);
    int                pick;
    logic [SIZE_W-1:0] size;
    logic [GIDX_W-1:0] idx;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      size = SIZE_W'($urandom_range(1, 400));
      idx  = GIDX_W'($urandom);
      if (pick < 8)
        size = SIZE_W'($urandom_range(1, 4096));
      else if (pick < 12)
        size = SIZE_W'($urandom);
      else if (pick < 14)
        size = 0;
      if (n == count / 2)
        wait_for_results();
      if (pick >= 55 && live_blocks.size() != 0) begin
        pick = $urandom_range(0, live_blocks.size() - 1);
        idx  = live_blocks[pick];
        live_blocks.delete(pick);
        send_request(OP_FREE, SIZE_W'($urandom), idx, random_gap());
      end else if (pick >= 50) begin
        send_request(OP_FREE, SIZE_W'($urandom), idx, random_gap());
      end else begin
        send_request(OP_ALLOC, size, idx, random_gap());
      end
    end
  endtask

  always @(negedge clk) begin
    alloc_result_t want;
    if (rst_n && out_strobe) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected word: status %0d index %0d frag %0d",
                   out_status, out_granted_index, out_frag_total);
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status || out_granted_index !== want.granted ||
            out_frag_total !== want.frag) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected status %0d index %0d frag %0d, got %0d %0d %0d",
                     want.status, want.granted, want.frag,
                     out_status, out_granted_index, out_frag_total);
        end
      end
    end
  end

  initial begin
    mismatches     = 0;
    rst_n          = 1'b0;
    start          = 1'b0;
    in_operation   = OP_ALLOC;
    in_size_bytes  = '0;
    in_block_index = '0;
    reset_heap_map();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(680);
    wait_for_results();
    repeat (400) @(posedge clk);
    if (mismatches == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

@@ bitmap_first_fit_allocator.f @@
rtl/bffa_pkg.sv
rtl/bffa_ram.sv
rtl/bitmap_first_fit_allocator.sv
tb/sv/testbench.sv
